@@ hdl/assert_macros.svh @@
// Assertion macros used by the delay queue top level.
// Depends on nothing; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TIDQ_ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tidq assertion failed");
`define TIDQ_ASSERT_NEVER(label, clk, rst_n, cond) \
    `TIDQ_ASSERT_PROP(label, clk, rst_n, !(cond))
`else
`define TIDQ_ASSERT_PROP(label, clk, rst_n, prop)
`define TIDQ_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hdl/tidq_pkg.sv @@
// Types, codes and constants of the timed index delay queue.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tidq_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int SLOT_FW   = 6;
    localparam int TAG_W     = 32;
    localparam int TIME_W    = 32;
    localparam int TERM_W    = 31;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [TAG_W-1:0]    TAG_NONE = '1;
    localparam logic [APB_AW-3:0]   REG_TERM = '0;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_DELETE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_IGNORE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_PUSH_OK      = 3'd0,
        KIND_PUSH_REFUSED = 3'd1,
        KIND_DEL_CLEARED  = 3'd2,
        KIND_DEL_IGNORED  = 3'd3,
        KIND_EXPIRED      = 3'd4,
        KIND_NONE_EXPIRED = 3'd5
    } t_kind;

    typedef struct packed {
        t_op                 operation;
        logic [SLOT_FW-1:0]  slot;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   now_ms;
    } t_in_word;

    typedef struct packed {
        t_kind               kind;
        logic [SLOT_FW-1:0]  out_slot;
        logic [TAG_W-1:0]    out_tag;
        logic                last;
    } t_out_word;

    typedef struct packed {
        logic                queued;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   stamp;
    } t_slot_ent;

    typedef struct packed {
        logic rd;
        logic push;
        logic pop;
    } t_fifo_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HEAD,
        ST_EVAL
    } t_state;

endpackage
`default_nettype wire

@@ hdl/tidq_regs.sv @@
// APB register file of the delay queue: holds the expiry term.
// Depends on tidq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tidq_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tidq_pkg::APB_AW-1:0]       paddr,
    input  logic [tidq_pkg::APB_DW-1:0]       pwdata,
    output logic [tidq_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    output logic [tidq_pkg::TERM_W-1:0]       o_term_ms
);

    logic [tidq_pkg::TERM_W-1:0] r_term_ms;
    logic                        sel_term;

    assign sel_term = (paddr[tidq_pkg::APB_AW-1:2] == tidq_pkg::REG_TERM);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_ms <= '0;
        end else if (psel && penable && pwrite && pready && sel_term) begin
            r_term_ms <= pwdata[tidq_pkg::TERM_W-1:0];
        end
    end

    assign prdata    = sel_term ? tidq_pkg::APB_DW'(r_term_ms) : '0;
    assign o_term_ms = r_term_ms;

endmodule
`default_nettype wire

@@ hdl/tidq_slot_store.sv @@
// Slot memory of the delay queue: queued flag, tag and push time per slot.
// Depends on tidq_pkg; an entry never written reads as unqueued with tag all ones.
`timescale 1ns / 1ps
`default_nettype none
module tidq_slot_store #(
    parameter  int SLOTS = tidq_pkg::SLOTS_DEF,
    localparam int AW    = $clog2(SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic                  i_wr_live,
    input  tidq_pkg::t_slot_ent   i_wr_data,
    output tidq_pkg::t_slot_ent   o_rd_data
);

    tidq_pkg::t_slot_ent mem [SLOTS];
    logic [SLOTS-1:0]    r_live;
    tidq_pkg::t_slot_ent r_rd_data;
    logic                r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_live[i_wr_addr] <= i_wr_live;
            end
            if (i_rd_en) begin
                r_rd_live <= r_live[i_rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_data = r_rd_data;
        if (!r_rd_live) begin
            o_rd_data.queued = 1'b0;
            o_rd_data.tag    = tidq_pkg::TAG_NONE;
        end
    end

endmodule
`default_nettype wire

@@ hdl/tidq_fifo.sv @@
// Slot index FIFO of the delay queue: memory, head, tail and fill count.
// Depends on tidq_pkg; the head entry is read into a register on request.
`timescale 1ns / 1ps
`default_nettype none
module tidq_fifo #(
    parameter  int SLOTS = tidq_pkg::SLOTS_DEF,
    localparam int AW    = $clog2(SLOTS),
    localparam int CW    = $clog2(SLOTS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tidq_pkg::t_fifo_cmd   i_cmd,
    input  logic [AW-1:0]         i_push_slot,
    output logic [AW-1:0]         o_head_slot,
    output tidq_pkg::t_fifo_stat  o_stat
);

    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

    logic [AW-1:0] mem [SLOTS];
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_rd_slot;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;

    assign n_head = !i_cmd.pop ? r_head :
                    (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign n_tail = !i_cmd.push ? r_tail :
                    (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_tail] <= i_push_slot;
        end
        if (i_cmd.rd) begin
            r_rd_slot <= mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            if (i_cmd.push && !i_cmd.pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop && !i_cmd.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head_slot  = r_rd_slot;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(SLOTS));

endmodule
`default_nettype wire

@@ hdl/timed_index_delay_queue_unit.sv @@
// Top level of the timed index delay queue: control sequencer and output register.
// Depends on tidq_pkg, tidq_regs, tidq_slot_store, tidq_fifo and assert_macros.svh.
//
// Keeps SLOTS slots, each with a tag, a push time and a queued flag in one slot
// memory, and a FIFO of queued slot indices in a second memory. Items are taken
// one at a time. A push or a delete reads the slot memory, then writes it back
// and loads the result. A check tick reads and judges head entries until the
// FIFO runs empty or a remaining head entry is read and judged not expired.
// Each pop reads the head index, then reads and clears that slot. Every expired
// entry gives one word; last marks the final word of a tick, so an expired word
// is held back until the next head entry is judged or the FIFO runs empty.
// Output stalls hold the sequencer. Slot state is ready right after reset; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module timed_index_delay_queue_unit #(
    parameter int SLOTS = tidq_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tidq_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tidq_pkg::t_out_word           o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tidq_pkg::APB_AW-1:0]   paddr,
    input  logic [tidq_pkg::APB_DW-1:0]   pwdata,
    output logic [tidq_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(SLOTS);
    localparam logic [tidq_pkg::SLOT_FW:0] SLOT_LIM = (tidq_pkg::SLOT_FW + 1)'(SLOTS);

    tidq_pkg::t_state        r_state;
    tidq_pkg::t_state        n_state;
    tidq_pkg::t_in_word      r_in;
    tidq_pkg::t_out_word     r_out_word;
    logic                    r_out_vld;
    logic                    r_pend_vld;
    logic                    n_pend_vld;
    logic [AW-1:0]           r_pend_slot;
    logic [tidq_pkg::TAG_W-1:0] r_pend_tag;
    logic                    pend_ld;

    logic [tidq_pkg::TERM_W-1:0] term_ms;
    logic                    in_acc;
    logic                    out_free;
    logic                    slot_ok;
    logic                    emit;
    tidq_pkg::t_out_word     emit_word;

    logic                    slot_rd;
    logic [AW-1:0]           slot_rd_addr;
    logic                    slot_wr;
    logic [AW-1:0]           slot_wr_addr;
    logic                    slot_wr_live;
    tidq_pkg::t_slot_ent     slot_wr_data;
    tidq_pkg::t_slot_ent     slot_q;

    tidq_pkg::t_fifo_cmd     fifo_cmd;
    tidq_pkg::t_fifo_stat    fifo_stat;
    logic [AW-1:0]           head_slot;

    logic [tidq_pkg::TIME_W-1:0] elapsed;
    logic                    elapsed_neg;
    logic                    expire;
    logic                    can_app;

    tidq_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_term_ms (term_ms)
    );

    tidq_slot_store #(.SLOTS(SLOTS)) u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (slot_rd),
        .i_rd_addr (slot_rd_addr),
        .i_wr_en   (slot_wr),
        .i_wr_addr (slot_wr_addr),
        .i_wr_live (slot_wr_live),
        .i_wr_data (slot_wr_data),
        .o_rd_data (slot_q)
    );

    tidq_fifo #(.SLOTS(SLOTS)) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (fifo_cmd),
        .i_push_slot (r_in.slot[AW-1:0]),
        .o_head_slot (head_slot),
        .o_stat      (fifo_stat)
    );

    assign o_in_stall  = (r_state != tidq_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign slot_ok     = ({1'b0, r_in.slot} < SLOT_LIM);
    assign elapsed     = r_in.now_ms - slot_q.stamp;
    assign elapsed_neg = elapsed[tidq_pkg::TIME_W-1];
    assign expire      = !elapsed_neg && (elapsed[tidq_pkg::TIME_W-2:0] > term_ms);
    assign can_app     = !slot_q.queued && !fifo_stat.full;

    always_comb begin
        n_state      = r_state;
        n_pend_vld   = r_pend_vld;
        pend_ld      = 1'b0;
        slot_rd      = 1'b0;
        slot_rd_addr = i_in_word.slot[AW-1:0];
        slot_wr      = 1'b0;
        slot_wr_addr = r_in.slot[AW-1:0];
        slot_wr_live = 1'b1;
        slot_wr_data = slot_q;
        fifo_cmd     = '0;
        emit         = 1'b0;
        emit_word    = '0;
        unique case (r_state)
            tidq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_word.operation)
                        tidq_pkg::OP_PUSH, tidq_pkg::OP_DELETE: begin
                            slot_rd = 1'b1;
                            n_state = tidq_pkg::ST_EXEC;
                        end
                        tidq_pkg::OP_CHECK: begin
                            fifo_cmd.rd = 1'b1;
                            n_pend_vld  = 1'b0;
                            n_state     = tidq_pkg::ST_HEAD;
                        end
                        tidq_pkg::OP_IGNORE: begin
                            n_state = tidq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tidq_pkg::ST_EXEC: begin
                if (out_free) begin
                    emit               = 1'b1;
                    emit_word.out_slot = r_in.slot;
                    emit_word.last     = 1'b1;
                    n_state            = tidq_pkg::ST_IDLE;
                    if (r_in.operation == tidq_pkg::OP_PUSH) begin
                        emit_word.kind = tidq_pkg::KIND_PUSH_REFUSED;
                        if (slot_ok && slot_q.tag == tidq_pkg::TAG_NONE) begin
                            slot_wr             = 1'b1;
                            slot_wr_data.queued = slot_q.queued || can_app;
                            slot_wr_data.tag    = r_in.tag;
                            slot_wr_data.stamp  = r_in.now_ms;
                            if (can_app) begin
                                fifo_cmd.push  = 1'b1;
                                emit_word.kind = tidq_pkg::KIND_PUSH_OK;
                            end
                        end
                    end else begin
                        emit_word.kind = tidq_pkg::KIND_DEL_IGNORED;
                        if (slot_ok && slot_q.tag != tidq_pkg::TAG_NONE &&
                            slot_q.tag == r_in.tag && slot_q.queued) begin
                            slot_wr          = 1'b1;
                            slot_wr_data.tag = tidq_pkg::TAG_NONE;
                            emit_word.kind   = tidq_pkg::KIND_DEL_CLEARED;
                        end
                    end
                end
            end
            tidq_pkg::ST_HEAD: begin
                if (!fifo_stat.empty) begin
                    slot_rd      = 1'b1;
                    slot_rd_addr = head_slot;
                    n_state      = tidq_pkg::ST_EVAL;
                end else if (out_free) begin
                    emit           = 1'b1;
                    emit_word.last = 1'b1;
                    n_state        = tidq_pkg::ST_IDLE;
                    if (r_pend_vld) begin
                        emit_word.kind     = tidq_pkg::KIND_EXPIRED;
                        emit_word.out_slot = tidq_pkg::SLOT_FW'(r_pend_slot);
                        emit_word.out_tag  = r_pend_tag;
                    end else begin
                        emit_word.kind = tidq_pkg::KIND_NONE_EXPIRED;
                    end
                end
            end
            tidq_pkg::ST_EVAL: begin
                if (out_free) begin
                    slot_wr_addr = head_slot;
                    if (r_pend_vld) begin
                        emit_word.kind     = tidq_pkg::KIND_EXPIRED;
                        emit_word.out_slot = tidq_pkg::SLOT_FW'(r_pend_slot);
                        emit_word.out_tag  = r_pend_tag;
                    end else begin
                        emit_word.kind = tidq_pkg::KIND_NONE_EXPIRED;
                    end
                    if (expire) begin
                        emit         = r_pend_vld;
                        slot_wr      = 1'b1;
                        slot_wr_live = 1'b0;
                        fifo_cmd.pop = 1'b1;
                        fifo_cmd.rd  = 1'b1;
                        pend_ld      = 1'b1;
                        n_pend_vld   = 1'b1;
                        n_state      = tidq_pkg::ST_HEAD;
                    end else begin
                        // zero a stamp that lies ahead of now
                        slot_wr            = elapsed_neg;
                        slot_wr_data.stamp = '0;
                        emit               = 1'b1;
                        emit_word.last     = 1'b1;
                        n_state            = tidq_pkg::ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tidq_pkg::ST_IDLE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
        if (pend_ld) begin
            r_pend_slot <= head_slot;
            r_pend_tag  <= slot_q.tag;
        end
        if (emit) begin
            r_out_word <= emit_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    `TIDQ_ASSERT_NEVER(a_push_on_full, i_clk, i_rst_n, fifo_cmd.push && fifo_stat.full)
    `TIDQ_ASSERT_NEVER(a_pop_on_empty, i_clk, i_rst_n, fifo_cmd.pop && fifo_stat.empty)
    `TIDQ_ASSERT_NEVER(a_slot_rw_overlap, i_clk, i_rst_n, slot_rd && slot_wr)
    `TIDQ_ASSERT_PROP(a_emit_needs_room, i_clk, i_rst_n, emit |-> out_free)

endmodule
`default_nettype wire
